/* sv/cauchy_distribution_unit_core_macros.svh */
// assertion macros for the cauchy distribution unit
// used by the top level only
`ifndef CAUCHY_DISTRIBUTION_UNIT_CORE_MACROS_SVH
`define CAUCHY_DISTRIBUTION_UNIT_CORE_MACROS_SVH
// implication checked every clock outside reset
`define CDU_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define CDU_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* sv/cdu_pkg.sv */
// shared constants, types and the arctangent table for the cauchy unit
// no dependencies
package cdu_pkg;
  localparam int CordicSteps = 32;
  localparam int BisectSteps = 64;
  localparam int StepW = 7;
  localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] InvPi = 64'h517CC1B727220A94;

  localparam logic [1:0] MODE_DENSITY = 2'd0;
  localparam logic [1:0] MODE_CDF     = 2'd1;
  localparam logic [1:0] MODE_INVERSE = 2'd2;

  localparam logic [1:0] CFG_CENTER = 2'd0;
  localparam logic [1:0] CFG_SCALE  = 2'd1;
  localparam logic [1:0] CFG_SLO    = 2'd2;
  localparam logic [1:0] CFG_SHI    = 2'd3;

  typedef struct packed {
    logic start;
    logic signed [47:0] x;
    logic [46:0] g;
  } cdf_req_t;

  typedef struct packed {
    logic done;
    logic [32:0] p;
  } cdf_rsp_t;

  // angle table, units pi*2^-62, built by the series at elaboration
  function automatic logic signed [63:0] atan_entry(input int i);
    logic signed [63:0] acc;
    logic [127:0] prod;
    int e;
    acc = 64'sd0;
    if (i == 0) return 64'sd1 <<< 60;
    for (int k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        if (k % 2 == 1) acc = acc - 64'((64'd1 << (62 - e)) / 64'(2 * k + 1));
        else acc = acc + 64'((64'd1 << (62 - e)) / 64'(2 * k + 1));
      end
    end
    prod = 128'(acc) * 128'(InvPi);
    return prod[127:64];
  endfunction
endpackage

/* sv/cdu_cordic.sv */
// cumulative probability unit: normalizing shift then one cordic step a cycle
// depends on cdu_pkg
module cdu_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [47:0] center,
  input  cdu_pkg::cdf_req_t  req,
  output cdu_pkg::cdf_rsp_t  rsp
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_NORM = 2'd1;
  localparam logic [1:0] S_ITER = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [cdu_pkg::StepW-1:0] step;
  logic signed [63:0] xv, yv, ang;
  logic neg;
  logic signed [48:0] d;
  logic [47:0] ad;
  logic [63:0] xs, ys;
  logic signed [63:0] tab_val, a;
  logic [32:0] res;

  assign d = 49'(req.x) - 49'(center);
  assign ad = d[48] ? 48'(-d) : 48'(d);
  assign xs = 64'(xv >>> step);
  assign ys = 64'(yv >>> step);

  always_comb begin
    tab_val = 64'sd0;
    for (int i = 0; i < cdu_pkg::CordicSteps; i++)
      if (step == cdu_pkg::StepW'(i)) tab_val = cdu_pkg::atan_entry(i);
  end

  always_comb begin
    a = ang + (64'sd1 <<< 61);
    if (a[63]) res = 33'd0;
    else begin
      a = (a + (64'sd1 <<< 29)) >>> 30;
      res = (a > (64'sd1 <<< 32)) ? 33'h1_0000_0000 : a[32:0];
    end
  end

  always_ff @(posedge clk) begin
    rsp.done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (req.start) begin
          xv <= 64'(req.g);
          yv <= 64'(ad);
          neg <= d[48];
          ang <= 64'sd0;
          state <= S_NORM;
        end
        // one bit of left shift a cycle until larger operand reaches 2^59
        S_NORM: begin
          if (xv[59] || yv[59]) begin
            if (neg) yv <= -yv;
            step <= '0;
            state <= S_ITER;
          end else begin
            xv <= xv <<< 1;
            yv <= yv <<< 1;
          end
        end
        S_ITER: begin
          if (!yv[63]) begin
            xv <= xv + ys; yv <= yv - xs; ang <= ang + tab_val;
          end else begin
            xv <= xv - ys; yv <= yv + xs; ang <= ang - tab_val;
          end
          if (step == cdu_pkg::StepW'(cdu_pkg::CordicSteps - 1)) state <= S_OUT;
          step <= step + 1'b1;
        end
        S_OUT: begin
          rsp.p <= res;
          rsp.done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/cdu_density.sv */
// density unit: multiplies over cycles then restoring division a bit a cycle
// depends on cdu_pkg
module cdu_density (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [47:0] center,
  input  logic signed [47:0] x,
  input  logic [46:0]        g,
  output logic               done,
  output logic [47:0]        dens
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;

  logic [2:0] state;
  logic [6:0] cnt;
  logic [63:0] ma, mb;
  logic [127:0] macc, num, den, rem, quo;
  logic [1:0] phase;
  logic [47:0] adr;
  logic signed [48:0] d;
  logic [128:0] rsh;
  logic [31:0] pp_a;
  logic [63:0] pp;

  assign d = 49'(x) - 49'(center);
  // one 32x32 partial product a cycle, four per 64-bit product
  assign pp_a = cnt[0] ? ma[63:32] : ma[31:0];
  assign pp = 64'(pp_a) * 64'(cnt[1] ? mb[63:32] : mb[31:0]);
  assign rsh = {rem, num[127]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (start) begin
          adr <= d[48] ? 48'(-d) : 48'(d);
          ma <= 64'(g); mb <= 64'(g);
          macc <= '0; cnt <= '0; phase <= 2'd0; den <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          macc <= macc + (128'(pp) << (32 * (int'(cnt[0]) + int'(cnt[1]))));
          cnt <= cnt + 1'b1;
          if (cnt[1:0] == 2'd3) begin
            cnt <= '0;
            phase <= phase + 1'b1;
            macc <= '0;
            case (phase)
              2'd0: begin
                den <= macc + (128'(pp) << 64);
                ma <= 64'(adr); mb <= 64'(adr);
              end
              2'd1: begin
                den <= (den + macc + (128'(pp) << 64)) << 16;
                ma <= 64'(g); mb <= cdu_pkg::InvPi;
              end
              default: begin
                num <= macc + (128'(pp) << 64);
                rem <= '0; quo <= '0; cnt <= '0;
                state <= S_DIV;
              end
            endcase
          end
        end
        S_DIV: begin
          num <= num << 1;
          if (rsh >= 129'(den)) begin
            rem <= 128'(rsh - 129'(den));
            quo <= {quo[126:0], 1'b1};
          end else begin
            rem <= rsh[127:0];
            quo <= {quo[126:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 7'd127) state <= S_OUT;
        end
        S_OUT: begin
          dens <= (quo[127:48] != '0) ? 48'hFFFF_FFFF_FFFF : quo[47:0];
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/cauchy_distribution_unit_core.sv */
// Cauchy distribution unit. An item is taken when start is high and busy low;
// a single result appears for one cycle with done and cannot be stalled.
// Density runs a multiply and a 128-step divide, cumulative a shift search
// plus 32 cordic steps, and inverse up to 66 cordic runs on the one shared
// cordic unit. Register writes are only taken while the unit is idle and no
// word is being started.
`include "cauchy_distribution_unit_core_macros.svh"
module cauchy_distribution_unit_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic signed [47:0] position,
  input  logic [31:0]        probability,
  input  logic               last_of_batch,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  output logic               done,
  output logic signed [47:0] located_point,
  output logic [47:0]        density_or_cdf,
  output logic               range_error,
  output logic               batch_end
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DENS = 3'd1;
  localparam logic [2:0] S_CDF  = 3'd2;
  localparam logic [2:0] S_PLO  = 3'd3;
  localparam logic [2:0] S_PHI  = 3'd4;
  localparam logic [2:0] S_BIS  = 3'd5;

  logic [2:0] state;
  logic signed [47:0] center, slo, shi, lo, hi, cx;
  logic [46:0] scale, g;
  logic [32:0] plo, phi, p;
  logic [cdu_pkg::StepW-1:0] iter;
  logic lob, cstart, dstart, ddone;
  logic [47:0] dval;
  logic signed [48:0] sum;
  cdu_pkg::cdf_req_t creq;
  cdu_pkg::cdf_rsp_t crsp;

  // registers only change between words
  assign cfg_ready = (state == S_IDLE) && !start;
  assign busy = (state != S_IDLE);
  assign g = (scale == '0) ? 47'd1 : scale;
  assign sum = 49'(lo) + 49'(hi);
  assign creq = '{start: cstart, x: cx, g: g};

  cdu_cordic u_cordic (.clk, .rst, .center, .req(creq), .rsp(crsp));
  cdu_density u_dens (.clk, .rst, .start(dstart), .center, .x(cx), .g,
    .done(ddone), .dens(dval));

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= '0; scale <= 47'd65536;
      slo <= -48'sd67108864; shi <= 48'sd67108864;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cdu_pkg::CFG_CENTER: center <= cfg_data;
        cdu_pkg::CFG_SCALE:  scale <= cfg_data[46:0];
        cdu_pkg::CFG_SLO:    slo <= cfg_data;
        cdu_pkg::CFG_SHI:    shi <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0; cstart <= 1'b0; dstart <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (start) begin
          lob <= last_of_batch;
          p <= 33'(probability);
          located_point <= '0; density_or_cdf <= '0; range_error <= 1'b0;
          if (mode == cdu_pkg::MODE_DENSITY) begin
            cx <= position; dstart <= 1'b1; state <= S_DENS;
          end else if (mode == cdu_pkg::MODE_CDF) begin
            cx <= position; cstart <= 1'b1; state <= S_CDF;
          end else if (mode == cdu_pkg::MODE_INVERSE && probability != '0) begin
            lo <= slo; hi <= shi; cx <= slo; cstart <= 1'b1; state <= S_PLO;
          end else begin
            range_error <= (mode == cdu_pkg::MODE_INVERSE);
            batch_end <= last_of_batch; done <= 1'b1;
          end
        end
        S_DENS: if (ddone) begin
          density_or_cdf <= dval; batch_end <= lob; done <= 1'b1; state <= S_IDLE;
        end
        S_CDF: if (crsp.done) begin
          density_or_cdf <= 48'(crsp.p); batch_end <= lob; done <= 1'b1;
          state <= S_IDLE;
        end
        S_PLO: if (crsp.done) begin
          plo <= crsp.p;
          if (p <= crsp.p) begin
            located_point <= lo; batch_end <= lob; done <= 1'b1; state <= S_IDLE;
          end else begin
            cx <= hi; cstart <= 1'b1; state <= S_PHI;
          end
        end
        S_PHI: if (crsp.done) begin
          phi <= crsp.p;
          if (p >= crsp.p) begin
            located_point <= hi; batch_end <= lob; done <= 1'b1; state <= S_IDLE;
          end else begin
            iter <= '0; cx <= sum[48:1]; cstart <= 1'b1; state <= S_BIS;
          end
        end
        S_BIS: if (crsp.done) begin
          if (p > crsp.p) begin lo <= cx; plo <= crsp.p; end
          else begin hi <= cx; phi <= crsp.p; end
          iter <= iter + 1'b1;
          if (iter == cdu_pkg::StepW'(cdu_pkg::BisectSteps - 1)) begin
            if (p > crsp.p)
              located_point <= ((p - crsp.p) < (phi - p)) ? cx : hi;
            else
              located_point <= ((p - plo) < (crsp.p - p)) ? lo : cx;
            batch_end <= lob; done <= 1'b1; state <= S_IDLE;
          end else begin
            if (p > crsp.p) cx <= 48'((49'(cx) + 49'(hi)) >>> 1);
            else cx <= 48'((49'(lo) + 49'(cx)) >>> 1);
            cstart <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CDU_ASSERT_IMP(a_done_idle, done, state == S_IDLE)
  `CDU_ASSERT_IMP(a_start_idle, cstart, state != S_IDLE && state != S_DENS)
  `CDU_ASSERT_NXT(a_dstart_dens, dstart, state == S_DENS)
  `CDU_ASSERT_IMP(a_err_inv, done && range_error, located_point == '0)
endmodule

/* dv/cauchy_distribution_unit_core_test.sv */
// self-checking testbench for cauchy_distribution_unit_core: density, cumulative
// and inverse modes checked against an in-bench fixed-point predictor
// depends on cdu_pkg and the top level rtl
`timescale 1ns / 1ps
module cauchy_distribution_unit_core_test;

  localparam logic [63:0] PI_FIX = 64'h3243F6A8885A308D;
  localparam logic [63:0] SAT48 = 64'hFFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int ARC_STEPS = 32;
  localparam int HALVINGS = 64;

  typedef struct {
    logic [1:0] md;
    logic signed [47:0] pos;
    logic [31:0] prob;
    logic last;
  } item_t;

  typedef struct {
    logic signed [47:0] point;
    logic [47:0] value;
    logic err;
    logic bend;
  } answer_t;

  logic clk, rst;
  logic start, busy;
  logic [1:0] mode;
  logic signed [47:0] position;
  logic [31:0] probability;
  logic last_of_batch;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [47:0] cfg_data;
  logic done;
  logic signed [47:0] located_point;
  logic [47:0] density_or_cdf;
  logic range_error, batch_end;

  cauchy_distribution_unit_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .position(position), .probability(probability), .last_of_batch(last_of_batch),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .located_point(located_point),
    .density_or_cdf(density_or_cdf), .range_error(range_error),
    .batch_end(batch_end)
  );

  item_t pending[$];
  answer_t awaited[$];
  longint center_r, slo_r, shi_r;
  logic [63:0] scale_r;
  logic [63:0] inv_pi;
  longint arc_tab[64];
  int errors, cycles, gap_left, burst_left, checked;
  int mode_count[3];

  always #5 clk = ~clk;

  function automatic logic [63:0] eff_scale();
    return scale_r == 0 ? 64'd1 : scale_r;
  endfunction

  function automatic void build_arc_table();
    longint acc, term;
    int e;
    logic [127:0] prod;
    inv_pi = 64'((128'd1 << 124) / 128'(PI_FIX));
    arc_tab[0] = longint'(64'd1 << 60);
    for (int i = 1; i < 64; i++) begin
      acc = 0;
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          term = longint'((64'd1 << (62 - e)) / 64'(2 * k + 1));
          if (k % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
      end
      prod = 128'(64'(acc)) * 128'(inv_pi);
      arc_tab[i] = longint'(prod[127:64]);
    end
  endfunction

  // cumulative probability, Q0.32 held in 33 bits
  function automatic logic [32:0] cum_prob(longint x);
    longint d, xv, yv, ang, a, xs, ys;
    logic [63:0] ad, m, g;
    int s;
    g = eff_scale();
    d = x - center_r;
    ad = 64'(d < 0 ? -d : d);
    m = ad > g ? ad : g;
    s = 0;
    while ((m << s) < 64'h0800_0000_0000_0000) s++;
    xv = longint'(g << s);
    yv = longint'(ad << s);
    if (d < 0) yv = -yv;
    ang = 0;
    for (int i = 0; i < ARC_STEPS; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv = xv + ys; yv = yv - xs; ang = ang + arc_tab[i];
      end else begin
        xv = xv - ys; yv = yv + xs; ang = ang - arc_tab[i];
      end
    end
    a = ang + longint'(64'h2000_0000_0000_0000);
    if (a < 0) return 33'd0;
    a = (a + longint'(64'd1 << 29)) >>> 30;
    if (a > longint'(64'd1 << 32)) return 33'h1_0000_0000;
    return a[32:0];
  endfunction

  function automatic answer_t predict_cauchy(item_t it);
    answer_t r;
    logic [127:0] num, den, q;
    logic [63:0] g, ad;
    longint d, lo, hi, mid, res;
    logic [32:0] plo, phi, pm;
    r.point = '0; r.value = '0; r.err = 1'b0; r.bend = it.last;
    g = eff_scale();
    if (it.md == cdu_pkg::MODE_DENSITY) begin
      d = longint'(it.pos) - center_r;
      ad = 64'(d < 0 ? -d : d);
      num = 128'(g) * 128'(inv_pi);
      den = (128'(g) * 128'(g) + 128'(ad) * 128'(ad)) << 16;
      q = num / den;
      r.value = q > 128'(SAT48) ? SAT48[47:0] : q[47:0];
    end else if (it.md == cdu_pkg::MODE_CDF) begin
      r.value = 48'(cum_prob(longint'(it.pos)));
    end else if (it.md == cdu_pkg::MODE_INVERSE) begin
      if (it.prob == 0) begin
        r.err = 1'b1;
      end else begin
        lo = slo_r; hi = shi_r;
        plo = cum_prob(lo); phi = cum_prob(hi);
        if ({1'b0, it.prob} <= plo) res = lo;
        else if ({1'b0, it.prob} >= phi) res = hi;
        else begin
          for (int i = 0; i < HALVINGS; i++) begin
            mid = (lo + hi) >>> 1;
            pm = cum_prob(mid);
            if ({1'b0, it.prob} > pm) begin
              lo = mid; plo = pm;
            end else begin
              hi = mid; phi = pm;
            end
          end
          res = (longint'(it.prob) - longint'(plo) < longint'(phi) - longint'(it.prob))
              ? lo : hi;
        end
        r.point = res[47:0];
      end
    end
    return r;
  endfunction

  // accept side: sample on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      cycles <= cycles + 1;
      if (start && !busy) begin
        awaited.push_back(predict_cauchy(pending[0]));
        mode_count[pending[0].md]++;
        pending.pop_front();
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 6);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
      if (done) begin
        if (awaited.size() == 0) begin
          $display("%0t: result word with nothing awaited", $time);
          errors++;
        end else begin
          if (located_point !== awaited[0].point) begin
            $display("%0t: located_point expected %0d got %0d", $time,
                     awaited[0].point, located_point);
            errors++;
          end
          if (density_or_cdf !== awaited[0].value) begin
            $display("%0t: density_or_cdf expected %0d got %0d", $time,
                     awaited[0].value, density_or_cdf);
            errors++;
          end
          if (range_error !== awaited[0].err) begin
            $display("%0t: range_error expected %0b got %0b", $time,
                     awaited[0].err, range_error);
            errors++;
          end
          if (batch_end !== awaited[0].bend) begin
            $display("%0t: batch_end expected %0b got %0b", $time,
                     awaited[0].bend, batch_end);
            errors++;
          end
          awaited.pop_front();
          checked++;
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout with %0d words awaited", awaited.size());
        $display("cauchy_distribution_unit_core_test: errors");
        $finish;
      end
    end
  end

  // drive side: change inputs on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      start <= 1'b0;
    end else if (pending.size() == 0) begin
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      mode <= pending[0].md;
      position <= pending[0].pos;
      probability <= pending[0].prob;
      last_of_batch <= pending[0].last;
    end
  end

  task automatic add_item(logic [1:0] md, logic [47:0] pos, logic [31:0] prob, logic last);
    item_t it;
    it.md = md; it.pos = pos; it.prob = prob; it.last = last;
    pending.push_back(it);
  endtask

  task automatic drain();
    wait (pending.size() == 0 && awaited.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [47:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cdu_pkg::CFG_CENTER: center_r = longint'($signed(data));
      cdu_pkg::CFG_SCALE: scale_r = 64'(data[46:0]);
      cdu_pkg::CFG_SLO: slo_r = longint'($signed(data));
      default: shi_r = longint'($signed(data));
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_regs(logic [47:0] c, logic [47:0] g, logic [47:0] l, logic [47:0] h);
    reg_write(cdu_pkg::CFG_CENTER, c);
    reg_write(cdu_pkg::CFG_SCALE, g);
    reg_write(cdu_pkg::CFG_SLO, l);
    reg_write(cdu_pkg::CFG_SHI, h);
  endtask

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom} & SAT48[47:0];
  endfunction

  task automatic random_items(int n);
    logic [1:0] md;
    logic [47:0] pos;
    logic [31:0] prob;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      md = r < 35 ? cdu_pkg::MODE_DENSITY
         : (r < 70 ? cdu_pkg::MODE_CDF : cdu_pkg::MODE_INVERSE);
      if ($urandom_range(0, 9) < 7)
        pos = 48'(center_r + (longint'($urandom_range(0, 2000)) - 1000)
                  * longint'(eff_scale()) / 100);
      else
        pos = rand48();
      r = $urandom_range(0, 9);
      prob = r == 0 ? 32'd0 : (r == 1 ? 32'($urandom_range(1, 100))
           : (r == 2 ? ~32'($urandom_range(0, 100)) : $urandom));
      add_item(md, pos, prob, 1'($urandom));
      // one pause per batch until every result is back
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    clk = 1'b0; rst = 1'b1;
    start = 1'b0; mode = cdu_pkg::MODE_DENSITY; position = '0; probability = '0;
    last_of_batch = 1'b0; cfg_valid = 1'b0; cfg_index = cdu_pkg::CFG_CENTER;
    cfg_data = '0;
    errors = 0; cycles = 0; checked = 0; gap_left = 0; burst_left = 1;
    mode_count = '{0, 0, 0};
    center_r = 0; scale_r = 64'd65536; slo_r = -67108864; shi_r = 67108864;
    build_arc_table();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed word set on reset settings
    add_item(cdu_pkg::MODE_DENSITY, 48'sd0, 32'd0, 1'b0);
    add_item(cdu_pkg::MODE_DENSITY, 48'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_item(cdu_pkg::MODE_DENSITY, 48'h8000_0000_0000, 32'd1, 1'b0);
    add_item(cdu_pkg::MODE_DENSITY, 48'sd65536, 32'd0, 1'b1);
    add_item(cdu_pkg::MODE_CDF, 48'sd0, 32'd0, 1'b0);
    add_item(cdu_pkg::MODE_CDF, 48'h7FFF_FFFF_FFFF, 32'd0, 1'b1);
    add_item(cdu_pkg::MODE_CDF, 48'h8000_0000_0000, 32'd0, 1'b0);
    add_item(cdu_pkg::MODE_CDF, 48'sd65536, 32'd0, 1'b0);
    add_item(cdu_pkg::MODE_CDF, -48'sd65536, 32'd0, 1'b1);
    add_item(cdu_pkg::MODE_INVERSE, 48'sd0, 32'd0, 1'b0);
    add_item(cdu_pkg::MODE_INVERSE, 48'h7FFF_FFFF_FFFF, 32'd1, 1'b1);
    add_item(cdu_pkg::MODE_INVERSE, 48'sd0, 32'hFFFF_FFFF, 1'b0);
    add_item(cdu_pkg::MODE_INVERSE, 48'sd0, 32'h8000_0000, 1'b1);
    add_item(cdu_pkg::MODE_INVERSE, 48'sd0, 32'h4000_0000, 1'b0);
    add_item(cdu_pkg::MODE_INVERSE, 48'sd0, 32'hC000_0000, 1'b1);
    add_item(cdu_pkg::MODE_INVERSE, 48'sd0, 32'h0000_8000, 1'b0);
    drain();

    // moderate random settings
    load_regs(48'(longint'($signed($urandom))), 48'($urandom_range(1024, 1 << 26)),
              -48'sd1073741824 + 48'($urandom_range(0, 1 << 20)),
              48'sd1073741824 + 48'($urandom_range(0, 1 << 20)));
    random_items(30);
    drain();

    // extremes of every register, scale mask bit set
    load_regs(48'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h8000_0000_0000,
              48'h7FFF_FFFF_FFFF);
    random_items(30);
    drain();

    // zero scale and reversed brackets
    load_regs(48'h8000_0000_0000, 48'd0, 48'sd67108864, -48'sd67108864);
    add_item(cdu_pkg::MODE_DENSITY, 48'h8000_0000_0000, 32'd0, 1'b1);
    random_items(30);
    drain();

    // fully random register contents
    load_regs(rand48(), rand48(), rand48(), rand48());
    random_items(30);
    drain();
    load_regs(48'sd0, 48'sd65536, -48'sd655360, 48'sd655360);
    random_items(30);
    drain();
    repeat (200) @(posedge clk);

    $display("covered %0d density, %0d cumulative, %0d inverse words; %0d results checked",
             mode_count[0], mode_count[1], mode_count[2], checked);
    $display("register settings: reset, moderate, extremes, zero scale, random");
    if (errors == 0 && awaited.size() == 0) begin
      $display("cauchy_distribution_unit_core_test: clean");
    end else begin
      $display("cauchy_distribution_unit_core_test: errors");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+sv
sv/cdu_pkg.sv
sv/cdu_cordic.sv
sv/cdu_density.sv
sv/cauchy_distribution_unit_core.sv
dv/cauchy_distribution_unit_core_test.sv
